>>> rtl/escaped_frame_receiver_assert.svh
// assertion macros for the escaped frame receiver
`ifndef ESCAPED_FRAME_RECEIVER_ASSERT_SVH
`define ESCAPED_FRAME_RECEIVER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked on every clock edge outside reset
`define EFR_ASSERT_IMPLIES(label, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// next-cycle implication
`define EFR_ASSERT_NEXT(label, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`else

`define EFR_ASSERT_IMPLIES(label, lhs, rhs, msg)
`define EFR_ASSERT_NEXT(label, lhs, rhs, msg)

`endif

`endif

>>> rtl/efr_pkg.sv
package efr_pkg;

    // framing bytes
    localparam logic [7:0] FLAG_BYTE   = 8'h7E;
    localparam logic [7:0] ESCAPE_BYTE = 8'h7D;

    // default limits
    localparam int DEFAULT_MAX_PAYLOAD = 255;
    localparam logic [19:0] TIMEOUT_RESET = 20'd20000;
    localparam logic [19:0] TICK_SATURATE = 20'hFFFFF;
    localparam logic [7:0]  COUNT_SATURATE = 8'hFF;

    // input commands
    localparam logic [1:0] CMD_BYTE = 2'd0;
    localparam logic [1:0] CMD_ARM  = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_REPORT  = 2'd1;
    localparam logic [1:0] KIND_EXTRA   = 2'd2;

    // header positions
    localparam logic [1:0] HDR_ADDRESS = 2'd0;
    localparam logic [1:0] HDR_COMMAND = 2'd1;
    localparam logic [1:0] HDR_STATUS  = 2'd2;
    localparam logic [1:0] HDR_LENGTH  = 2'd3;

    // receive phases
    typedef enum logic [6:0] {
        PH_UNARMED = 7'b0000001,
        PH_START   = 7'b0000010,
        PH_HEADER  = 7'b0000100,
        PH_DATA    = 7'b0001000,
        PH_SUM     = 7'b0010000,
        PH_END     = 7'b0100000,
        PH_DONE    = 7'b1000000
    } phase_t;

    // one result transaction
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] payload_byte;
        logic [7:0] frame_address;
        logic [7:0] frame_command;
        logic [6:0] device_status;
        logic       device_error;
        logic [7:0] data_length;
        logic       timed_out;
        logic       checksum_error;
        logic       overflow;
        logic       missing_end;
    } result_t;

    // unescape the byte that follows an escape mark
    function automatic logic [7:0] map_escaped(input logic [7:0] b);
        logic [7:0] m;
        unique case (b)
            8'h31:   m = 8'h11;
            8'h33:   m = 8'h13;
            8'h5D:   m = 8'h7D;
            8'h5E:   m = 8'h7E;
            default: m = b;
        endcase
        return m;
    endfunction

endpackage

>>> rtl/escaped_frame_receiver.sv
// Escaped frame receiver: after an arm transaction it hunts for a 0x7E start
// byte, unescapes and collects four header bytes, the payload and a checksum,
// and issues one frame report on the closing byte or on timeout (counted in
// tick transactions against timeout_ticks, written through cfg_we/cfg_wdata;
// the user must write it only while idle, which the block does not enforce).
// Payload bytes within the armed limit come out as they arrive; bytes after
// the report come out as extra notices. One transaction is taken every cycle
// while in_ready is high; each passes an input register and then the result
// register, and a stalled result holds the input register, dropping in_ready.
`include "escaped_frame_receiver_assert.svh"

module escaped_frame_receiver
    import efr_pkg::*;
#(
    parameter int MAX_PAYLOAD = DEFAULT_MAX_PAYLOAD
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [19:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [7:0]  rx_byte,
    input  logic [7:0]  max_length,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  payload_byte,
    output logic [7:0]  frame_address,
    output logic [7:0]  frame_command,
    output logic [6:0]  device_status,
    output logic        device_error,
    output logic [7:0]  data_length,
    output logic        timed_out,
    output logic        checksum_error,
    output logic        overflow,
    output logic        missing_end
);

    localparam logic [7:0] LIMIT_MAX = 8'(MAX_PAYLOAD);

    // configuration
    logic [19:0] timeout_ticks_reg;

    // input register
    logic        stage_valid_reg;
    logic [1:0]  stage_cmd_reg;
    logic [7:0]  stage_byte_reg;
    logic [7:0]  stage_maxl_reg;

    // receive state
    phase_t      phase_reg, phase_next;
    logic [1:0]  header_index_reg, header_index_next;
    logic [7:0]  header_store_reg [4];
    logic [7:0]  header_store_next [4];
    logic [7:0]  payload_count_reg, payload_count_next;
    logic        escape_pending_reg, escape_pending_next;
    logic [7:0]  running_sum_reg, running_sum_next;
    logic [7:0]  received_sum_reg, received_sum_next;
    logic [19:0] tick_count_reg, tick_count_next;
    logic [7:0]  length_limit_reg, length_limit_next;

    // result register
    logic        out_valid_reg, out_valid_next;
    result_t     result_reg, result_next;
    logic        result_fire;

    logic        advance;
    logic        process;
    logic [7:0]  data_byte;
    logic [19:0] tick_inc;
    logic [7:0]  count_inc;

    // handshakes
    assign advance  = !out_valid_reg || out_ready;
    assign process  = stage_valid_reg && advance;
    assign in_ready = !stage_valid_reg || advance;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_ticks_reg <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            timeout_ticks_reg <= cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stage_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stage_cmd_reg  <= command;
            stage_byte_reg <= rx_byte;
            stage_maxl_reg <= max_length;
        end
    end

    assign data_byte = escape_pending_reg ? map_escaped(stage_byte_reg) : stage_byte_reg;
    assign tick_inc  = (tick_count_reg < TICK_SATURATE) ? tick_count_reg + 20'd1
                                                        : tick_count_reg;
    assign count_inc = (payload_count_reg < COUNT_SATURATE) ? payload_count_reg + 8'd1
                                                            : payload_count_reg;

    // per-transaction state update and result formation
    always_comb
    begin
        logic make_report;
        logic report_tmo;
        logic report_noend;
        logic ovf;

        phase_next          = phase_reg;
        header_index_next   = header_index_reg;
        header_store_next   = header_store_reg;
        payload_count_next  = payload_count_reg;
        escape_pending_next = escape_pending_reg;
        running_sum_next    = running_sum_reg;
        received_sum_next   = received_sum_reg;
        tick_count_next     = tick_count_reg;
        length_limit_next   = length_limit_reg;
        result_next         = '0;
        result_fire         = 1'b0;
        make_report         = 1'b0;
        report_tmo          = 1'b0;
        report_noend        = 1'b0;

        priority if (stage_cmd_reg == CMD_ARM)
        begin
            phase_next          = PH_START;
            header_index_next   = '0;
            payload_count_next  = '0;
            escape_pending_next = 1'b0;
            running_sum_next    = '0;
            received_sum_next   = '0;
            tick_count_next     = '0;
            length_limit_next   = (stage_maxl_reg > LIMIT_MAX) ? LIMIT_MAX : stage_maxl_reg;
        end
        else if (stage_cmd_reg == CMD_TICK)
        begin
            if (phase_reg != PH_UNARMED && phase_reg != PH_DONE)
            begin
                tick_count_next = tick_inc;
                if (tick_inc >= timeout_ticks_reg)
                begin
                    make_report = 1'b1;
                    report_tmo  = 1'b1;
                end
            end
        end
        else if (stage_cmd_reg == CMD_BYTE)
        begin
            unique case (phase_reg)
                PH_START:
                begin
                    if (stage_byte_reg == FLAG_BYTE)
                    begin
                        phase_next = PH_HEADER;
                    end
                end
                PH_END:
                begin
                    make_report  = 1'b1;
                    report_noend = (stage_byte_reg != FLAG_BYTE);
                end
                PH_DONE:
                begin
                    result_fire              = 1'b1;
                    result_next.kind         = KIND_EXTRA;
                    result_next.payload_byte = stage_byte_reg;
                end
                PH_HEADER, PH_DATA, PH_SUM:
                begin
                    if (!escape_pending_reg && stage_byte_reg == ESCAPE_BYTE)
                    begin
                        escape_pending_next = 1'b1;
                    end
                    else
                    begin
                        escape_pending_next = 1'b0;
                        unique case (phase_reg)
                            PH_HEADER:
                            begin
                                header_store_next[header_index_reg] = data_byte;
                                running_sum_next = running_sum_reg + data_byte;
                                if (header_index_reg == HDR_LENGTH)
                                begin
                                    phase_next = (data_byte != 8'd0) ? PH_DATA : PH_SUM;
                                end
                                else
                                begin
                                    header_index_next = header_index_reg + 2'd1;
                                end
                            end
                            PH_DATA:
                            begin
                                running_sum_next   = running_sum_reg + data_byte;
                                payload_count_next = count_inc;
                                if (count_inc >= header_store_reg[HDR_LENGTH])
                                begin
                                    phase_next = PH_SUM;
                                end
                                if (payload_count_reg < length_limit_reg)
                                begin
                                    result_fire              = 1'b1;
                                    result_next.kind         = KIND_PAYLOAD;
                                    result_next.payload_byte = data_byte;
                                end
                            end
                            default:
                            begin
                                received_sum_next = data_byte;
                                phase_next        = PH_END;
                            end
                        endcase
                    end
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
        end

        // frame report from the stored header and sums
        ovf = (header_store_reg[HDR_LENGTH] > length_limit_reg);
        if (make_report)
        begin
            phase_next                 = PH_DONE;
            result_fire                = 1'b1;
            result_next.kind           = KIND_REPORT;
            result_next.frame_address  = header_store_reg[HDR_ADDRESS];
            result_next.frame_command  = header_store_reg[HDR_COMMAND];
            result_next.device_status  = header_store_reg[HDR_STATUS][6:0];
            result_next.device_error   = header_store_reg[HDR_STATUS][7];
            result_next.data_length    = ovf ? length_limit_reg : header_store_reg[HDR_LENGTH];
            result_next.timed_out      = report_tmo;
            result_next.checksum_error = (received_sum_reg != ~running_sum_reg);
            result_next.overflow       = ovf;
            result_next.missing_end    = report_noend;
        end
    end

    // receive state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_UNARMED;
            header_index_reg   <= '0;
            header_store_reg   <= '{default: 8'd0};
            payload_count_reg  <= '0;
            escape_pending_reg <= 1'b0;
            running_sum_reg    <= '0;
            received_sum_reg   <= '0;
            tick_count_reg     <= '0;
            length_limit_reg   <= '0;
        end
        else if (process)
        begin
            phase_reg          <= phase_next;
            header_index_reg   <= header_index_next;
            header_store_reg   <= header_store_next;
            payload_count_reg  <= payload_count_next;
            escape_pending_reg <= escape_pending_next;
            running_sum_reg    <= running_sum_next;
            received_sum_reg   <= received_sum_next;
            tick_count_reg     <= tick_count_next;
            length_limit_reg   <= length_limit_next;
        end
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (process && result_fire)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process && result_fire)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = result_reg.kind;
    assign payload_byte   = result_reg.payload_byte;
    assign frame_address  = result_reg.frame_address;
    assign frame_command  = result_reg.frame_command;
    assign device_status  = result_reg.device_status;
    assign device_error   = result_reg.device_error;
    assign data_length    = result_reg.data_length;
    assign timed_out      = result_reg.timed_out;
    assign checksum_error = result_reg.checksum_error;
    assign overflow       = result_reg.overflow;
    assign missing_end    = result_reg.missing_end;

    // checks
    `EFR_ASSERT_IMPLIES(a_ready_stall, !in_ready, stage_valid_reg && out_valid_reg && !out_ready, "in_ready low without a stalled result")
    `EFR_ASSERT_IMPLIES(a_start_index, phase_reg == PH_START, header_index_reg == 2'd0, "header index not cleared while hunting for start")
    `EFR_ASSERT_IMPLIES(a_data_count, phase_reg == PH_DATA, payload_count_reg < header_store_reg[HDR_LENGTH], "payload count reached header length in data phase")

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps

module tb;
    import efr_pkg::*;

    // clocking, pauses and run length
    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 6;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_CYCLES    = 8;
    localparam int HOLD_OFF_CYCLES = 300;
    // longest quiet stretch of a good run is the receiver hold-off; sender gaps and
    // receiver stalls at 65 in a hundred are far shorter
    localparam int STALL_LIMIT     = 4000;
    localparam int RANDOM_ITEMS    = 1700;
    localparam int MAX_PAYLOAD     = DEFAULT_MAX_PAYLOAD;
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [19:0] cfg_wdata = 20'h0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  command = CMD_BYTE;
    logic [7:0]  rx_byte = 8'h00;
    logic [7:0]  max_length = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [7:0]  frame_address;
    logic [7:0]  frame_command;
    logic [6:0]  device_status;
    logic        device_error;
    logic [7:0]  data_length;
    logic        timed_out;
    logic        checksum_error;
    logic        overflow;
    logic        missing_end;

    // mirrored receiver state
    phase_t      rx_phase      = PH_UNARMED;
    logic [1:0]  hdr_pos       = HDR_ADDRESS;
    logic [7:0]  hdr_bytes [4] = '{default: 8'h00};
    logic [7:0]  data_seen     = 8'h00;
    bit          esc_pending   = 1'b0;
    logic [7:0]  byte_sum      = 8'h00;
    logic [7:0]  sum_field     = 8'h00;
    logic [19:0] ticks_seen    = 20'h0;
    logic [7:0]  data_limit    = 8'h00;
    logic [19:0] timeout_value = TIMEOUT_RESET;

    result_t     frame_outputs_due [$];
    int          effective_items = 0;
    int          mismatch_count  = 0;
    int          send_idle_pct   = 0;
    int          recv_stall_pct  = 0;
    int          tick_pct        = 0;
    int          hold_request    = 0;

    escaped_frame_receiver DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .rx_byte        (rx_byte),
        .max_length     (max_length),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .payload_byte   (payload_byte),
        .frame_address  (frame_address),
        .frame_command  (frame_command),
        .device_status  (device_status),
        .device_error   (device_error),
        .data_length    (data_length),
        .timed_out      (timed_out),
        .checksum_error (checksum_error),
        .overflow       (overflow),
        .missing_end    (missing_end)
    );

    // clock
    initial
    begin
        forever #HALF_PERIOD clk = ~clk;
    end

    // frame report from the header, sums and limit held so far
    function automatic result_t close_frame(input bit tmo, input bit noend);
        result_t r;
        bit ovf;
        ovf = hdr_bytes[HDR_LENGTH] > data_limit;
        r = '0;
        r.kind           = KIND_REPORT;
        r.frame_address  = hdr_bytes[HDR_ADDRESS];
        r.frame_command  = hdr_bytes[HDR_COMMAND];
        r.device_status  = hdr_bytes[HDR_STATUS][6:0];
        r.device_error   = hdr_bytes[HDR_STATUS][7];
        r.data_length    = ovf ? data_limit : hdr_bytes[HDR_LENGTH];
        r.timed_out      = tmo;
        r.checksum_error = (sum_field != 8'(~byte_sum));
        r.overflow       = ovf;
        r.missing_end    = noend;
        rx_phase = PH_DONE;
        return r;
    endfunction

    // unescape and place one header, payload or checksum byte
    task automatic take_frame_byte(input logic [7:0] raw);
        logic [7:0] b;
        result_t r;
        b = raw;
        if (esc_pending)
        begin
            esc_pending = 1'b0;
            case (raw)
                8'h31:   b = 8'h11;
                8'h33:   b = 8'h13;
                8'h5D:   b = ESCAPE_BYTE;
                8'h5E:   b = FLAG_BYTE;
                default: b = raw;
            endcase
        end
        else if (raw == ESCAPE_BYTE)
        begin
            esc_pending = 1'b1;
            return;
        end
        case (rx_phase)
            PH_HEADER:
            begin
                hdr_bytes[hdr_pos] = b;
                byte_sum = byte_sum + b;
                if (hdr_pos == HDR_LENGTH)
                    rx_phase = (b != 8'h00) ? PH_DATA : PH_SUM;
                else
                    hdr_pos = hdr_pos + 2'd1;
            end
            PH_DATA:
            begin
                r = '0;
                r.kind = KIND_PAYLOAD;
                r.payload_byte = b;
                // passed out only while under the armed limit
                if (data_seen < data_limit)
                    frame_outputs_due.push_back(r);
                byte_sum = byte_sum + b;
                if (data_seen != COUNT_SATURATE)
                    data_seen = data_seen + 8'd1;
                if (data_seen >= hdr_bytes[HDR_LENGTH])
                    rx_phase = PH_SUM;
            end
            default:
            begin
                sum_field = b;
                rx_phase = PH_END;
            end
        endcase
    endtask

    // expected results of one accepted transaction
    task automatic track_frame(input logic [1:0] c, input logic [7:0] raw,
                               input logic [7:0] m);
        result_t r;
        case (c)
            CMD_ARM:
            begin
                effective_items++;
                rx_phase    = PH_START;
                hdr_pos     = HDR_ADDRESS;
                data_seen   = 8'h00;
                esc_pending = 1'b0;
                byte_sum    = 8'h00;
                sum_field   = 8'h00;
                ticks_seen  = 20'h0;
                data_limit  = (m > MAX_PAYLOAD) ? 8'(MAX_PAYLOAD) : m;
            end
            CMD_TICK:
            begin
                // ignored before arming and once reported
                if (rx_phase != PH_UNARMED && rx_phase != PH_DONE)
                begin
                    effective_items++;
                    if (ticks_seen != TICK_SATURATE)
                        ticks_seen = ticks_seen + 20'd1;
                    if (ticks_seen >= timeout_value)
                        frame_outputs_due.push_back(close_frame(1'b1, 1'b0));
                end
            end
            CMD_BYTE:
            begin
                if (rx_phase != PH_UNARMED)
                    effective_items++;
                case (rx_phase)
                    PH_START:
                    begin
                        if (raw == FLAG_BYTE)
                            rx_phase = PH_HEADER;
                    end
                    PH_END:
                        frame_outputs_due.push_back(close_frame(1'b0, raw != FLAG_BYTE));
                    PH_DONE:
                    begin
                        r = '0;
                        r.kind = KIND_EXTRA;
                        r.payload_byte = raw;
                        frame_outputs_due.push_back(r);
                    end
                    PH_HEADER, PH_DATA, PH_SUM:
                        take_frame_byte(raw);
                    default: ;
                endcase
            end
            default: ;
        endcase
    endtask

    // one input transaction, with random sender gaps
    task automatic send_item(input logic [1:0] c, input logic [7:0] b, input logic [7:0] m);
        bit taken;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= c;
        rx_byte    <= b;
        max_length <= m;
        do
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        while (!taken);
        track_frame(c, b, m);
    endtask

    // line byte with the odd tick or unknown command slipped in ahead
    task automatic send_line_byte(input logic [7:0] b);
        if ($urandom_range(99) < tick_pct)
            send_item(CMD_TICK, 8'($urandom), 8'($urandom));
        if ($urandom_range(199) == 0)
            send_item(CMD_UNKNOWN, 8'($urandom), 8'($urandom));
        send_item(CMD_BYTE, b, 8'($urandom));
    endtask

    // byte stuffing, with optional and needless escapes
    task automatic send_stuffed(input logic [7:0] v);
        logic [7:0] code;
        bit esc;
        code = v;
        esc = ($urandom_range(99) < 3);
        case (v)
            ESCAPE_BYTE:
            begin
                esc = 1'b1;
                code = 8'h5D;
            end
            FLAG_BYTE:
            begin
                esc = ($urandom_range(3) != 0);
                code = esc ? 8'h5E : v;
            end
            8'h11:
            begin
                esc = ($urandom_range(3) != 0);
                code = esc ? 8'h31 : v;
            end
            8'h13:
            begin
                esc = ($urandom_range(3) != 0);
                code = esc ? 8'h33 : v;
            end
            // these would be remapped after an escape
            8'h31, 8'h33, 8'h5D, 8'h5E:
                esc = 1'b0;
            default: ;
        endcase
        if (esc)
            send_line_byte(ESCAPE_BYTE);
        send_line_byte(code);
    endtask

    // random byte leaning towards the ones that need stuffing
    function automatic logic [7:0] random_line_value();
        logic [7:0] v;
        v = 8'($urandom);
        if ($urandom_range(3) == 0)
        begin
            case ($urandom_range(3))
                0:       v = FLAG_BYTE;
                1:       v = ESCAPE_BYTE;
                2:       v = 8'h11;
                default: v = 8'h13;
            endcase
        end
        return v;
    endfunction

    // arm, then one frame with random content; may be cut short or damaged
    task automatic send_frame(input logic [7:0] maxl, input int len, input bit allow_break);
        logic [7:0] hdr [4];
        logic [7:0] v;
        logic [7:0] sum;
        int cut;
        hdr[HDR_ADDRESS] = random_line_value();
        hdr[HDR_COMMAND] = random_line_value();
        hdr[HDR_STATUS]  = random_line_value();
        hdr[HDR_LENGTH]  = 8'(len);
        cut = -1;
        if (allow_break && $urandom_range(99) < 15)
            cut = $urandom_range(0, len + 4);
        send_item(CMD_ARM, 8'($urandom), maxl);
        // line noise while the start byte is hunted for
        repeat ($urandom_range(0, 2))
        begin
            v = 8'($urandom);
            send_line_byte((v == FLAG_BYTE) ? 8'h00 : v);
        end
        send_line_byte(FLAG_BYTE);
        // header, payload and checksum
        sum = 8'h00;
        for (int i = 0; i <= len + 4; i++)
        begin
            if (i == cut)
            begin
                // abandoned frame: run the tick count out where that is quick
                if (timeout_value <= 40)
                    repeat (timeout_value + 1)
                        send_item(CMD_TICK, 8'($urandom), 8'($urandom));
                return;
            end
            if (i < 4)
                v = hdr[i];
            else if (i < len + 4)
                v = random_line_value();
            else if (allow_break && $urandom_range(99) < 10)
                v = 8'($urandom);
            else
                v = ~sum;
            sum = sum + v;
            send_stuffed(v);
        end
        // closing byte, now and then wrong
        if (allow_break && $urandom_range(99) < 10)
            send_line_byte(8'($urandom));
        else
            send_line_byte(FLAG_BYTE);
        // stray traffic after the report
        repeat ($urandom_range(0, 2))
        begin
            if ($urandom_range(1) == 0)
                send_item(CMD_TICK, 8'($urandom), 8'($urandom));
            else
                send_item(CMD_BYTE, 8'($urandom), 8'($urandom));
        end
    endtask

    // timeout register write once the block has gone quiet
    task automatic write_timeout(input logic [19:0] v);
        in_valid <= 1'b0;
        while (frame_outputs_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        timeout_value = v;
    endtask

    task automatic test_unarmed_input();
        send_item(CMD_BYTE, FLAG_BYTE, 8'h00);
        send_item(CMD_TICK, 8'hFF, 8'hFF);
        send_item(CMD_UNKNOWN, 8'h00, 8'h00);
    endtask

    // zero timeout: the first tick after arming reports
    task automatic test_zero_timeout();
        write_timeout(20'h0);
        send_item(CMD_ARM, 8'h00, 8'hFF);
        send_item(CMD_BYTE, FLAG_BYTE, 8'h00);
        send_item(CMD_TICK, 8'h00, 8'h00);
        send_item(CMD_TICK, 8'h00, 8'h00);
        send_item(CMD_BYTE, 8'hFF, 8'h00);
    endtask

    // every escape code, a raw start byte as data, good checksum
    task automatic test_escaped_frame();
        write_timeout(TICK_SATURATE);
        send_item(CMD_ARM, 8'hFF, 8'hFF);
        send_item(CMD_BYTE, FLAG_BYTE, 8'h00);
        // header 7E 11 FF 03
        send_item(CMD_BYTE, ESCAPE_BYTE, 8'h00);
        send_item(CMD_BYTE, 8'h5E, 8'h00);
        send_item(CMD_BYTE, ESCAPE_BYTE, 8'h00);
        send_item(CMD_BYTE, 8'h31, 8'h00);
        send_item(CMD_BYTE, 8'hFF, 8'h00);
        send_item(CMD_BYTE, 8'h03, 8'h00);
        // payload 13 7D 7E
        send_item(CMD_BYTE, ESCAPE_BYTE, 8'h00);
        send_item(CMD_BYTE, 8'h33, 8'h00);
        send_item(CMD_BYTE, ESCAPE_BYTE, 8'h00);
        send_item(CMD_BYTE, 8'h5D, 8'h00);
        send_item(CMD_BYTE, FLAG_BYTE, 8'h00);
        // checksum and closing byte
        send_item(CMD_BYTE, 8'h60, 8'h00);
        send_item(CMD_BYTE, FLAG_BYTE, 8'h00);
    endtask

    // zero limit, bad checksum and no closing byte
    task automatic test_overflow_frame();
        send_item(CMD_ARM, 8'h00, 8'h00);
        send_item(CMD_BYTE, FLAG_BYTE, 8'h00);
        send_item(CMD_BYTE, 8'h01, 8'h00);
        send_item(CMD_BYTE, 8'h02, 8'h00);
        send_item(CMD_BYTE, 8'h00, 8'h00);
        send_item(CMD_BYTE, 8'h01, 8'h00);
        send_item(CMD_BYTE, 8'hAA, 8'h00);
        send_item(CMD_BYTE, 8'h00, 8'h00);
        send_item(CMD_BYTE, 8'h00, 8'h00);
    endtask

    // long receiver hold-off while frames keep coming
    task automatic test_output_hold_off();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        tick_pct       = 0;
        hold_request   = HOLD_OFF_CYCLES;
        send_frame(8'hFF, 12, 1'b0);
        send_frame(8'hFF, 12, 1'b0);
    endtask

    task automatic test_random_traffic();
        int goal;
        int len;
        int pick;
        logic [7:0] maxl;
        for (int p = 0; p < 8; p++)
        begin
            case (p / 2)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 65;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 65;
                end
                default:
                begin
                    send_idle_pct  = 33;
                    recv_stall_pct = 33;
                end
            endcase
            // long timeouts with few ticks, then short ones where frames die
            if (p % 2 == 0)
            begin
                if (p == 0)
                    write_timeout(TIMEOUT_RESET);
                else if (p == 4)
                    write_timeout(TICK_SATURATE);
                else
                    write_timeout(20'($urandom_range(500, 1048575)));
                tick_pct = 4;
            end
            else
            begin
                if (p == 1)
                    write_timeout(20'd1);
                else
                    write_timeout(20'($urandom_range(2, 30)));
                tick_pct = 12;
            end
            goal = effective_items + RANDOM_ITEMS / 8;
            while (effective_items < goal)
            begin
                pick = $urandom_range(99);
                if (pick < 20)
                    len = 0;
                else if (pick < 75)
                    len = $urandom_range(1, 8);
                else if (pick < 96)
                    len = $urandom_range(9, 40);
                else
                    len = $urandom_range(200, 255);
                pick = $urandom_range(99);
                if (pick < 40)
                    maxl = 8'hFF;
                else if (pick < 70)
                    maxl = 8'($urandom);
                else
                    maxl = 8'($urandom_range(0, 10));
                send_frame(maxl, len, 1'b1);
            end
        end
    endtask

    // receiver: random stalls, and the hold-off counted here
    initial
    begin : result_sink
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic void check_field(input string tag, input logic [7:0] want_v,
                                        input logic [7:0] got_v);
        if (got_v !== want_v)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch: expected %02h, got %02h",
                     $time, tag, want_v, got_v);
        end
    endfunction

    // compare each result transaction with the oldest one outstanding
    initial
    begin : result_check
        result_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (frame_outputs_due.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result with nothing outstanding: %s %0d byte %02h",
                             $time, "expected none, got kind", kind, payload_byte);
                end
                else
                begin
                    want = frame_outputs_due.pop_front();
                    check_field("kind", 8'(want.kind), 8'(kind));
                    check_field("payload_byte", want.payload_byte, payload_byte);
                    check_field("frame_address", want.frame_address, frame_address);
                    check_field("frame_command", want.frame_command, frame_command);
                    check_field("device_status", 8'(want.device_status), 8'(device_status));
                    check_field("device_error", 8'(want.device_error), 8'(device_error));
                    check_field("data_length", want.data_length, data_length);
                    check_field("timed_out", 8'(want.timed_out), 8'(timed_out));
                    check_field("checksum_error", 8'(want.checksum_error),
                                8'(checksum_error));
                    check_field("overflow", 8'(want.overflow), 8'(overflow));
                    check_field("missing_end", 8'(want.missing_end), 8'(missing_end));
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(negedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        test_unarmed_input();
        test_zero_timeout();
        test_escaped_frame();
        test_overflow_frame();
        test_output_hold_off();
        test_random_traffic();
        // drain
        in_valid <= 1'b0;
        while (frame_outputs_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
